FILE: hw/rtl/kpdeb_pkg.sv
`default_nettype none

package kpdeb_pkg;

  // Widths that the interface fixes.
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned KEY_IDX_W = 4;
  localparam int unsigned LIMIT_W   = 4;

  // Debounce limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/keypad_integrator_debounce_events_unit.sv
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------
// in       | input     | in_valid_i/in_stall_o   | raw_keys_i
// out      | output    | out_valid_o/out_stall_i | key_index_o, is_release_o, last_event_o
// cfg      | input     | cfg_we_i (no stall)     | cfg_wdata_i (debounce limit)
//
// One scan transaction walks the integrators (one key per cycle through a
// single shared update/compare unit), then loads its events in turn into the
// output register, each when the register is empty or being drained.
// The input channel is stalled from acceptance until the last event of the scan
// has been loaded into the output register; that last event may still wait there
// while the next scan transaction is accepted.
// A scan that changes no key produces no output transaction.
// Reset clears all integrators, the debounced key states and the sequencer, and
// sets the debounce limit to 3.
module keypad_integrator_debounce_events_unit #(
  parameter int unsigned NUM_KEYS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [kpdeb_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [kpdeb_pkg::RAW_W-1:0]      raw_keys_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [kpdeb_pkg::KEY_IDX_W-1:0]       key_index_o,
  output logic                                  is_release_o,
  output logic                                  last_event_o
);

  import kpdeb_pkg::*;

  localparam int unsigned KeyW = $clog2(NUM_KEYS);
  localparam int unsigned CntW = $clog2(NUM_KEYS + 1);

  state_e state_q, state_d;

  // Debounce limit register.
  logic [LIMIT_W-1:0] limit_q;

  // Per-key state: saturating integrator and debounced pressed bit.
  logic [LIMIT_W-1:0] integ_q [NUM_KEYS];
  logic [NUM_KEYS-1:0] stable_q;

  // Raw mask of the scan in progress, shifted right by one key per cycle.
  logic [RAW_W-1:0] raw_q;
  logic [KeyW-1:0]  scan_cnt_q;

  // Event buffers: press events and release events, each in ascending key order.
  logic [KEY_IDX_W-1:0] press_buf [NUM_KEYS];
  logic [KEY_IDX_W-1:0] rel_buf   [NUM_KEYS];
  logic [CntW-1:0]      press_cnt_q, press_cnt_d;
  logic [CntW-1:0]      rel_cnt_q, rel_cnt_d;

  // Emission pointer and phase (0 = press events, 1 = release events).
  logic [CntW-1:0] ptr_q;
  logic            phase_q;

  // Output register.
  logic                 out_valid_q;
  logic [KEY_IDX_W-1:0] key_q;
  logic                 rel_q;
  logic                 last_q;

  // The shared integrator update unit works on the key under the scan counter.
  logic [LIMIT_W-1:0] limit_eff;
  logic [LIMIT_W-1:0] integ_cur;
  logic [LIMIT_W-1:0] integ_new;
  logic               was_pressed;
  logic               raw_bit;
  logic               key_press;
  logic               key_release;
  logic               scan_last;
  logic [6:0]         key_ext;

  logic               in_accept;
  logic               load;
  logic               press_last;
  logic               rel_last;
  logic [CntW-1:0]    ptr_inc;

  // A limit of zero behaves as a limit of one.
  assign limit_eff   = (limit_q == '0) ? LIMIT_W'(1) : limit_q;
  assign integ_cur   = integ_q[scan_cnt_q];
  assign was_pressed = stable_q[scan_cnt_q];
  assign raw_bit     = raw_q[0];
  assign scan_last   = (scan_cnt_q == KeyW'(NUM_KEYS - 1));
  assign key_ext     = 7'(scan_cnt_q);

  always_comb begin
    integ_new = integ_cur;
    if (raw_bit) begin
      if (integ_cur < limit_eff) begin
        integ_new = integ_cur + LIMIT_W'(1);
      end
    end else if (integ_cur != '0) begin
      integ_new = integ_cur - LIMIT_W'(1);
    end
  end

  // Both tests use the debounced state from before this scan, so a key changes
  // at most once per scan. An integrator left above a lowered limit still counts
  // as having reached it.
  assign key_press   = !was_pressed && (integ_new >= limit_eff);
  assign key_release = was_pressed && (integ_new == '0);

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // In emission the output register takes a new event whenever it is empty or being drained.
  assign load       = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign ptr_inc    = ptr_q + CntW'(1);
  assign press_last = (ptr_inc == press_cnt_q);
  assign rel_last   = (ptr_inc == rel_cnt_q);

  always_comb begin
    press_cnt_d = press_cnt_q;
    rel_cnt_d   = rel_cnt_q;
    if (in_accept) begin
      press_cnt_d = '0;
      rel_cnt_d   = '0;
    end else if (state_q == ST_SCAN) begin
      if (key_press) begin
        press_cnt_d = press_cnt_q + CntW'(1);
      end
      if (key_release) begin
        rel_cnt_d = rel_cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = (press_cnt_d != '0 || rel_cnt_d != '0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (!phase_q && press_last && rel_cnt_q == '0) begin
            state_d = ST_IDLE;
          end else if (phase_q && rel_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer, counters and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      scan_cnt_q  <= '0;
      press_cnt_q <= '0;
      rel_cnt_q   <= '0;
      ptr_q       <= '0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      press_cnt_q <= press_cnt_d;
      rel_cnt_q   <= rel_cnt_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        scan_cnt_q <= '0;
      end else if (state_q == ST_SCAN) begin
        scan_cnt_q <= scan_cnt_q + KeyW'(1);
      end
      if (state_q == ST_SCAN && scan_last) begin
        ptr_q   <= '0;
        phase_q <= (press_cnt_d == '0);
      end else if (load) begin
        if (!phase_q && press_last) begin
          ptr_q   <= '0;
          phase_q <= 1'b1;
        end else begin
          ptr_q <= ptr_inc;
        end
      end
    end
  end

  // Per-key integrators and debounced state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        integ_q[k] <= '0;
      end
      stable_q <= '0;
    end else if (state_q == ST_SCAN) begin
      integ_q[scan_cnt_q] <= integ_new;
      if (key_press) begin
        stable_q[scan_cnt_q] <= 1'b1;
      end else if (key_release) begin
        stable_q[scan_cnt_q] <= 1'b0;
      end
    end
  end

  // Raw mask shifter; keys beyond the raw mask width read as released.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q <= raw_keys_i;
    end else if (state_q == ST_SCAN) begin
      raw_q <= raw_q >> 1;
    end
  end

  // Event buffers, written during the scan and read during emission.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      if (key_press) begin
        press_buf[press_cnt_q[KeyW-1:0]] <= key_ext[KEY_IDX_W-1:0];
      end
      if (key_release) begin
        rel_buf[rel_cnt_q[KeyW-1:0]] <= key_ext[KEY_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (phase_q) begin
        key_q  <= rel_buf[ptr_q[KeyW-1:0]];
        rel_q  <= 1'b1;
        last_q <= rel_last;
      end else begin
        key_q  <= press_buf[ptr_q[KeyW-1:0]];
        rel_q  <= 1'b0;
        last_q <= press_last && (rel_cnt_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_index_o  = key_q;
  assign is_release_o = rel_q;
  assign last_event_o = last_q;

  // Emission only starts when the scan found at least one changed key.
  a_emit_has_events : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (press_cnt_q != '0 || rel_cnt_q != '0))
    else $error("emission without any recorded event");

  // A key cannot both press and release in one scan.
  a_event_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ((CntW+1)'(press_cnt_q) + (CntW+1)'(rel_cnt_q)
                              <= (CntW+1)'(NUM_KEYS)))
    else $error("more events than keys");

  // Every scan walks the keys from the first one.
  a_scan_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_SCAN) |-> (scan_cnt_q == '0))
    else $error("scan did not start at key zero");

  // After the final event of a scan is taken, no further event follows at once.
  a_last_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_event_o && state_q == ST_IDLE)
    |=> !out_valid_o)
    else $error("event after the last event of a scan");

endmodule

`default_nettype wire

FILE: verif/kpdeb_event_checker.sv
// Checker for the keypad debounce event unit. It watches the scan, event and
// limit ports, keeps its own model of the integrators, and scores every event
// transaction against the oldest predicted event.
module kpdeb_event_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kpdeb_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [kpdeb_pkg::RAW_W-1:0]      raw_keys_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [kpdeb_pkg::KEY_IDX_W-1:0]  key_index_i,
  input  logic                             is_release_i,
  input  logic                             last_event_i,
  output int                               errors_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEYS = 16;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic PRESS_EV   = 1'b0;
  localparam logic RELEASE_EV = 1'b1;

  typedef struct packed {
    logic [kpdeb_pkg::KEY_IDX_W-1:0] key_index;
    logic                            is_release;
    logic                            last_event;
  } key_event_t;

  logic [kpdeb_pkg::LIMIT_W-1:0] integ [KEYS];
  logic [KEYS-1:0]               stable_keys;
  logic [kpdeb_pkg::LIMIT_W-1:0] limit_q;
  key_event_t                    expected_events [$];
  int                            mismatches;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: event mismatch: %s", $realtime, what);
    end
  endtask

  // One scan tick: step every integrator, then queue press events followed by
  // release events, each in ascending key order, last one flagged.
  task automatic debounce_tick(input logic [KEYS-1:0] raw);
    logic [kpdeb_pkg::LIMIT_W-1:0] lim;
    logic [kpdeb_pkg::LIMIT_W-1:0] v;
    logic [KEYS-1:0]               presses;
    logic [KEYS-1:0]               releases;
    key_event_t                    ev;
    int                            total;
    int                            k;
    int                            i;
    lim = (limit_q == '0) ? 4'd1 : limit_q;
    presses  = '0;
    releases = '0;
    for (i = 0; i < KEYS; i++) begin
      v = integ[i];
      if (raw[i]) begin
        if (v < lim) v++;
      end else if (v != '0) begin
        v--;
      end
      integ[i] = v;
      if (!stable_keys[i] && v >= lim) begin
        stable_keys[i] = 1'b1;
        presses[i]     = 1'b1;
      end else if (stable_keys[i] && v == '0) begin
        stable_keys[i] = 1'b0;
        releases[i]    = 1'b1;
      end
    end
    total = $countones(presses) + $countones(releases);
    k = 0;
    for (i = 0; i < KEYS; i++) begin
      if (presses[i]) begin
        ev.key_index  = i[kpdeb_pkg::KEY_IDX_W-1:0];
        ev.is_release = PRESS_EV;
        ev.last_event = (k + 1 == total);
        expected_events.push_back(ev);
        k++;
      end
    end
    for (i = 0; i < KEYS; i++) begin
      if (releases[i]) begin
        ev.key_index  = i[kpdeb_pkg::KEY_IDX_W-1:0];
        ev.is_release = RELEASE_EV;
        ev.last_event = (k + 1 == total);
        expected_events.push_back(ev);
        k++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_event_t exp_ev;
    int         i;
    if (!rst_ni) begin
      for (i = 0; i < KEYS; i++) integ[i] = '0;
      stable_keys = '0;
      limit_q     = kpdeb_pkg::LIMIT_RESET;
      expected_events.delete();
      mismatches  = 0;
    end else begin
      // Events are scored before the scan of this edge is predicted; a scan
      // accepted now cannot have produced an event yet.
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          note_mismatch($sformatf("unexpected event key=%0d rel=%0b last=%0b",
                                  key_index_i, is_release_i, last_event_i));
        end else begin
          exp_ev = expected_events.pop_front();
          if (key_index_i !== exp_ev.key_index) begin
            note_mismatch($sformatf("key_index expected %0d got %0d",
                                    exp_ev.key_index, key_index_i));
          end
          if (is_release_i !== exp_ev.is_release) begin
            note_mismatch($sformatf("is_release expected %0b got %0b (key %0d)",
                                    exp_ev.is_release, is_release_i, exp_ev.key_index));
          end
          if (last_event_i !== exp_ev.last_event) begin
            note_mismatch($sformatf("last_event expected %0b got %0b (key %0d)",
                                    exp_ev.last_event, last_event_i, exp_ev.key_index));
          end
        end
      end
      if (in_valid_i && !in_stall_i) debounce_tick(raw_keys_i);
      if (cfg_we_i) limit_q = cfg_wdata_i;
    end
    errors_o  <= mismatches;
    pending_o <= expected_events.size();
  end

endmodule

FILE: verif/tb_keypad_integrator_debounce_events_unit.sv
// Top of the keypad debounce event testbench. This module only produces
// stimulus and gives the verdict; all prediction and scoring lives in the
// checker instantiated next to the block.
module tb_keypad_integrator_debounce_events_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog limit is far above the slowest legal run: roughly 300 scans,
  // each taking a full walk of the integrators plus up to sixteen events that
  // may each sit behind receiver stalls, plus the long hold-off and the idle
  // pauses around every limit change.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // The settle time is longer than a full walk of the integrators, so it covers
  // a scan that is still in flight without producing any event.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned BASE_IDLE_PCT = 6;

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             cfg_we       = 1'b0;
  logic [kpdeb_pkg::LIMIT_W-1:0]    cfg_wdata    = '0;
  logic                             in_valid     = 1'b0;
  logic                             in_stall;
  logic [kpdeb_pkg::RAW_W-1:0]      raw_keys     = '0;
  logic                             out_valid;
  logic                             out_stall    = 1'b0;
  logic [kpdeb_pkg::KEY_IDX_W-1:0]  key_index;
  logic                             is_release;
  logic                             last_event;

  int          errors;
  int          pending;
  int unsigned cycle_cnt     = 0;
  int unsigned idle_pct      = BASE_IDLE_PCT;
  int unsigned stall_pct     = BASE_IDLE_PCT;
  logic        hold_request  = 1'b0;
  logic        hold_started  = 1'b0;
  int unsigned hold_left     = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  keypad_integrator_debounce_events_unit #(
    .NUM_KEYS(16)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .raw_keys_i  (raw_keys),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .key_index_o (key_index),
    .is_release_o(is_release),
    .last_event_o(last_event)
  );

  kpdeb_event_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .raw_keys_i  (raw_keys),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .key_index_i (key_index),
    .is_release_i(is_release),
    .last_event_i(last_event),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Receiver side. Normally it stalls at random; once the stimulus raises the
  // hold request it stalls solidly for a counted stretch so that the event
  // register and the scan sequencer both back up and the input gets stalled.
  always @(posedge clk_i) begin
    if (hold_request && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog. A hung block or a lost event ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one scan transaction and return at the edge where it is taken. The
  // valid stays high on return, so a back-to-back scan only changes the data.
  task automatic send_scan(input logic [kpdeb_pkg::RAW_W-1:0] keys);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    raw_keys <= keys;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Stop offering scans until every predicted event has been seen and the
  // block has had time to finish a scan that produces no event at all.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || in_stall) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Limit changes only happen on a quiet block.
  task automatic write_limit(input logic [kpdeb_pkg::LIMIT_W-1:0] value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Random scans that look like real key activity: a target mask is held for
  // a run of ticks long enough to cross most limits, with sparse bounce noise
  // flipped in now and then. Targets favor all-released and all-pressed.
  task automatic random_scans(input int unsigned count);
    logic [kpdeb_pkg::RAW_W-1:0] target;
    logic [kpdeb_pkg::RAW_W-1:0] noise;
    int unsigned                 run_left;
    run_left = 0;
    target   = '0;
    repeat (count) begin
      if (run_left == 0) begin
        case ($urandom_range(5))
          0:       target = '0;
          1:       target = '1;
          default: target = 16'($urandom);
        endcase
        run_left = $urandom_range(20, 1);
      end
      run_left--;
      noise = ($urandom_range(3) == 0) ? 16'($urandom & $urandom & $urandom) : '0;
      send_scan(target ^ noise);
    end
  endtask

  initial begin
    logic [kpdeb_pkg::LIMIT_W-1:0] phase_limits [8];
    int                            p;

    phase_limits = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd7, 4'd3, 4'd9, 4'd4};
    phase_limits[5] = 4'($urandom_range(14, 1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset limit of three.
    // A quiet scan produces nothing.
    send_scan(16'h0000);
    // Every key pressed for three ticks: sixteen press events in one scan.
    repeat (3) send_scan(16'hFFFF);
    // Every key released for three ticks: sixteen release events.
    repeat (3) send_scan(16'h0000);
    // Low byte pressed, then swapped for the high byte so that eight keys
    // settle pressed on the same tick that eight others settle released;
    // presses must come out ahead of releases.
    repeat (3) send_scan(16'h00FF);
    repeat (3) send_scan(16'hFF00);

    // A zero limit behaves like a limit of one.
    write_limit(4'd0);
    send_scan(16'h5555);
    send_scan(16'hAAAA);
    send_scan(16'hFFFF);
    send_scan(16'h0000);

    // Limit lowered below a running integrator: the key counts as having
    // reached the new limit without counting up any further.
    write_limit(4'd5);
    repeat (4) send_scan(16'h000F);
    write_limit(4'd2);
    send_scan(16'h000F);

    // Random part, one limit per phase. Each phase begins from a quiet block,
    // so the sender also pauses until every expected event has arrived.
    for (p = 0; p < 8; p++) begin
      write_limit(phase_limits[p]);
      if (p == 0) begin
        // Long receiver hold-off while scans keep coming. With a limit of one
        // every toggle flips at least twelve keys, so the block fills quickly.
        hold_request <= 1'b1;
        for (int j = 0; j < 10; j++) send_scan(j[0] ? 16'h0000 : 16'hFFFF);
        random_scans(22);
      end else if (p == 3) begin
        // A stretch with no idling on either side.
        idle_pct  = 0;
        stall_pct = 0;
        random_scans(32);
        idle_pct  = BASE_IDLE_PCT;
        stall_pct = BASE_IDLE_PCT;
      end else begin
        random_scans(32);
      end
    end

    wait_quiet();
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/kpdeb_pkg.sv
hw/rtl/keypad_integrator_debounce_events_unit.sv
verif/kpdeb_event_checker.sv
verif/tb_keypad_integrator_debounce_events_unit.sv
